// ===== rtl/core/opl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list package
// Shared widths, command and status codes, and payload types for the ordered
// list engine.
// ----------------------------------------------------------------------------
package opl_pkg;

  localparam int Capacity   = 64;
  localparam int EntryWidth = 32;
  localparam int IdxW       = $clog2(Capacity);
  localparam int CntW       = $clog2(Capacity + 1);

  // Command codes.
  localparam logic [3:0] CMD_APPEND       = 4'd0;
  localparam logic [3:0] CMD_PREPEND      = 4'd1;
  localparam logic [3:0] CMD_INSERT       = 4'd2;
  localparam logic [3:0] CMD_REPLACE      = 4'd3;
  localparam logic [3:0] CMD_REMOVE_AT    = 4'd4;
  localparam logic [3:0] CMD_REMOVE_VALUE = 4'd5;
  localparam logic [3:0] CMD_REMOVE_LAST  = 4'd6;
  localparam logic [3:0] CMD_CLEAR        = 4'd7;
  localparam logic [3:0] CMD_FIND         = 4'd8;
  localparam logic [3:0] CMD_READ         = 4'd9;
  localparam logic [3:0] CMD_BEFORE       = 4'd10;
  localparam logic [3:0] CMD_FIRST        = 4'd11;
  localparam logic [3:0] CMD_LAST         = 4'd12;
  localparam logic [3:0] CMD_COMPACT      = 4'd13;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_POS   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [3:0]            command;
    logic [EntryWidth-1:0] entry_value;
    logic [CntW-1:0]       position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [EntryWidth-1:0] result_value;
    logic [IdxW-1:0]       found_position;
    logic [CntW-1:0]       entry_count;
  } out_item_t;

endpackage

// ===== rtl/core/opl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list entry RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module opl_ram (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [opl_pkg::IdxW-1:0]            wr_addr,
  input  logic [opl_pkg::EntryWidth-1:0]      wr_data,
  input  logic [opl_pkg::IdxW-1:0]            rd_addr,
  output logic [opl_pkg::EntryWidth-1:0]      rd_data
);

  logic [opl_pkg::EntryWidth-1:0] mem [opl_pkg::Capacity];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/ordered_pointer_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list held in one RAM, with search, shift and compact walks.
// ----------------------------------------------------------------------------
// One command is processed at a time. Commands that touch at most one entry
// need no walk. Search, shift-insert, shift-remove and compact walk the
// stored entries through the single RAM read port, one entry per cycle;
// remove_value and a checked insert walk twice (search, then shift). The
// result sits in an output register; a new command is taken in the cycle
// after that result has been handed off.
module ordered_pointer_list_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  opl_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output opl_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int IW = opl_pkg::IdxW;
  localparam int CW = opl_pkg::CntW;
  localparam int EW = opl_pkg::EntryWidth;

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SRCH    = 4'd1;  // search walk, issue reads
  localparam logic [3:0] S_DECIDE  = 4'd2;  // decide after search
  localparam logic [3:0] S_SHUP    = 4'd3;  // shift up for insert
  localparam logic [3:0] S_SHDN    = 4'd4;  // shift down for remove
  localparam logic [3:0] S_COMPACT = 4'd5;
  localparam logic [3:0] S_RD      = 4'd6;  // single read returns
  localparam logic [3:0] S_DONE    = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic        dup_r;
  opl_pkg::in_item_t cmd_r, cmd_nxt;
  opl_pkg::out_item_t res_r, res_nxt;

  // Walk control.
  logic [CW-1:0] idx_r, idx_nxt;       // read address counter
  logic          pend_r, pend_nxt;     // a read was issued last cycle
  logic [CW-1:0] pidx_r, pidx_nxt;     // address of that read
  logic [CW-1:0] wj_r, wj_nxt;         // compact write pointer
  logic          hit_r, hit_nxt;
  logic [CW-1:0] hidx_r, hidx_nxt;
  logic [EW-1:0] prev_r, prev_nxt;     // entry before the current one
  logic [EW-1:0] hval_r, hval_nxt;     // value before the match

  logic          wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;

  opl_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;
  assign cfg_ready = 1'b1;

  logic [CW-1:0] pos_c;
  assign pos_c = cmd_r.position;

  // Position of an incoming command lies below the count.
  logic          in_pos_ok;
  assign in_pos_ok = (in_data.position < count_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd_nxt   = cmd_r;
    res_nxt   = res_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    pidx_nxt  = idx_r;
    wj_nxt    = wj_r;
    hit_nxt   = hit_r;
    hidx_nxt  = hidx_r;
    prev_nxt  = prev_r;
    hval_nxt  = hval_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = cmd_r.entry_value;
    rd_addr   = idx_r[IW-1:0];

    case (state_r)
      // Command decode on acceptance; failures found here go straight to done.
      S_IDLE: begin
        idx_nxt = '0;
        hit_nxt = 1'b0;
        hidx_nxt = '0;
        wj_nxt  = '0;
        res_nxt = '0;
        if (in_valid) begin
          cmd_nxt  = in_data;
          prev_nxt = '0;
          case (in_data.command)
            opl_pkg::CMD_APPEND, opl_pkg::CMD_PREPEND, opl_pkg::CMD_INSERT: begin
              // Append and prepend are inserts at fixed positions.
              if (in_data.command == opl_pkg::CMD_APPEND) cmd_nxt.position = count_r;
              if (in_data.command == opl_pkg::CMD_PREPEND) cmd_nxt.position = '0;
              if (in_data.command == opl_pkg::CMD_INSERT &&
                  in_data.position > count_r) begin
                res_nxt.status = opl_pkg::ST_BAD_POS;
                state_nxt = S_DONE;
              end else if (dup_r) begin
                state_nxt = S_DECIDE;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            opl_pkg::CMD_REPLACE: begin
              if (!in_pos_ok) begin
                res_nxt.status = opl_pkg::ST_BAD_POS;
                state_nxt = S_DONE;
              end else if (dup_r || in_data.entry_value == '0) begin
                state_nxt = S_DECIDE;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            opl_pkg::CMD_REMOVE_AT: begin
              if (in_pos_ok) begin
                idx_nxt   = in_data.position + 1'b1;
                state_nxt = S_SHDN;
              end else begin
                res_nxt.status = opl_pkg::ST_BAD_POS;
                state_nxt = S_DONE;
              end
            end
            opl_pkg::CMD_REMOVE_VALUE, opl_pkg::CMD_FIND, opl_pkg::CMD_BEFORE:
              state_nxt = S_SRCH;
            opl_pkg::CMD_REMOVE_LAST: begin
              if (count_r != '0) count_nxt = count_r - 1'b1;
              else res_nxt.status = opl_pkg::ST_NOT_FOUND;
              state_nxt = S_DONE;
            end
            opl_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            opl_pkg::CMD_READ: begin
              if (in_pos_ok) begin
                rd_addr   = in_data.position[IW-1:0];
                state_nxt = S_RD;
              end else begin
                res_nxt.status = opl_pkg::ST_BAD_POS;
                state_nxt = S_DONE;
              end
            end
            opl_pkg::CMD_FIRST, opl_pkg::CMD_LAST: begin
              if (count_r != '0) begin
                if (in_data.command == opl_pkg::CMD_LAST) rd_addr = IW'(count_r - 1'b1);
                else rd_addr = '0;
                state_nxt = S_RD;
              end else begin
                res_nxt.status = opl_pkg::ST_NOT_FOUND;
                state_nxt = S_DONE;
              end
            end
            opl_pkg::CMD_COMPACT: state_nxt = S_COMPACT;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Linear search: one read issued per cycle, compared in the cycle after.
      S_SRCH: begin
        if (pend_r && !hit_r) begin
          if (rd_data == cmd_r.entry_value) begin
            hit_nxt  = 1'b1;
            hidx_nxt = pidx_r;
            hval_nxt = (pidx_r == '0) ? '0 : prev_r;
            res_nxt.result_value = rd_data;
          end
          prev_nxt = rd_data;
        end
        if (!hit_nxt && idx_r < count_r) begin
          rd_addr  = idx_r[IW-1:0];
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + 1'b1;
        end else if (!pend_r || hit_nxt || idx_r >= count_r) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_nxt.status = opl_pkg::ST_OK;
        case (cmd_r.command)
          opl_pkg::CMD_APPEND, opl_pkg::CMD_PREPEND, opl_pkg::CMD_INSERT: begin
            if (hit_r) begin
              res_nxt.status = opl_pkg::ST_DUPLICATE;
              state_nxt = S_DONE;
            end else begin
              res_nxt.result_value = '0;
              if (count_r >= CW'(opl_pkg::Capacity)) begin
                res_nxt.status = opl_pkg::ST_FULL;
                state_nxt = S_DONE;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_SHUP;
              end
            end
          end
          opl_pkg::CMD_REPLACE: begin
            if (hit_r) begin
              res_nxt.status = opl_pkg::ST_DUPLICATE;
            end else begin
              wr_en   = 1'b1;
              wr_addr = pos_c[IW-1:0];
              res_nxt.result_value = cmd_r.entry_value;
            end
            state_nxt = S_DONE;
          end
          opl_pkg::CMD_REMOVE_VALUE: begin
            res_nxt.result_value = '0;
            if (hit_r) begin
              res_nxt.found_position = hidx_r[IW-1:0];
              idx_nxt   = hidx_r + 1'b1;
              state_nxt = S_SHDN;
            end else begin
              res_nxt.status = opl_pkg::ST_NOT_FOUND;
              state_nxt = S_DONE;
            end
          end
          opl_pkg::CMD_FIND: begin
            res_nxt.result_value = '0;
            if (hit_r) res_nxt.found_position = hidx_r[IW-1:0];
            else res_nxt.status = opl_pkg::ST_NOT_FOUND;
            state_nxt = S_DONE;
          end
          default: begin
            // Before: entry preceding the first match.
            if (hit_r && hidx_r != '0) begin
              res_nxt.result_value = hval_r;
            end else begin
              res_nxt.result_value = '0;
              res_nxt.status = opl_pkg::ST_NOT_FOUND;
            end
            state_nxt = S_DONE;
          end
        endcase
      end

      // Shift up: read k-1, write it to k, down to the insert position.
      S_SHUP: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pidx_r[IW-1:0] + 1'b1;
          wr_data = rd_data;
        end
        if (idx_r > pos_c) begin
          rd_addr  = IW'(idx_r - 1'b1);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r - 1'b1;
          idx_nxt  = idx_r - 1'b1;
        end else if (!pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pos_c[IW-1:0];
          wr_data = cmd_r.entry_value;
          count_nxt = count_r + 1'b1;
          res_nxt.result_value = cmd_r.entry_value;
          state_nxt = S_DONE;
        end
      end

      // Shift down: read k, write it to k-1.
      S_SHDN: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = IW'(pidx_r - 1'b1);
          wr_data = rd_data;
        end
        if (idx_r < count_r) begin
          rd_addr  = idx_r[IW-1:0];
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + 1'b1;
        end else if (!pend_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      // Compact: copy nonzero entries down to the write pointer.
      S_COMPACT: begin
        if (pend_r && rd_data != '0) begin
          wr_en   = 1'b1;
          wr_addr = wj_r[IW-1:0];
          wr_data = rd_data;
          wj_nxt  = wj_r + 1'b1;
        end
        if (idx_r < count_r) begin
          rd_addr  = idx_r[IW-1:0];
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
          idx_nxt  = idx_r + 1'b1;
        end else if (!pend_r) begin
          count_nxt = wj_r;
          state_nxt = S_DONE;
        end
      end

      // Single read issued on acceptance; data valid here.
      S_RD: begin
        res_nxt.result_value = rd_data;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res_nxt.entry_count = count_r;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and the duplicate setting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      dup_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) dup_r <= cfg_data;
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    wj_r   <= wj_nxt;
    hit_r  <= hit_nxt;
    hidx_r <= hidx_nxt;
    prev_r <= prev_nxt;
    hval_r <= hval_nxt;
    res_r  <= res_nxt;
  end

endmodule
